// File: hdl/boet_pkg.sv
package boet_pkg;

  localparam int READ_COUNT_DEF  = 65536;
  localparam int LENGTH_BITS_DEF = 20;
  localparam int EVALUE_BITS_DEF = 12;

  localparam int ID_W   = 16;
  localparam int HANG_W = 21;
  localparam int EV_W   = 12;
  localparam int ER_W   = 16;
  localparam int RL_W   = 20;
  localparam int SC_W   = 32;

  typedef enum logic [2:0] {
    OP_SET_LENGTH    = 3'd0,
    OP_MARK_SUSP     = 3'd1,
    OP_MARK_MEMBER   = 3'd2,
    OP_SCORE_CONTAIN = 3'd3,
    OP_SCORE_EDGE    = 3'd4,
    OP_CLEAR_IF_CONT = 3'd5,
    OP_READ_BEST     = 3'd6,
    OP_CLEAR_READ    = 3'd7
  } opcode_t;

  typedef enum logic [3:0] {
    ST_DONE        = 4'd0,
    ST_BAD_QUALITY = 4'd1,
    ST_RESTRICTED  = 4'd2,
    ST_SUSPICIOUS  = 4'd3,
    ST_SHAPE       = 4'd4,
    ST_CONTAINED   = 4'd5,
    ST_NOT_BETTER  = 4'd6,
    ST_NEW_BEST    = 4'd7,
    ST_MARKED      = 4'd8
  } status_t;

  localparam logic [1:0] CFG_GOOD     = 2'd0;
  localparam logic [1:0] CFG_FALLBACK = 2'd1;
  localparam logic [1:0] CFG_RESTRICT = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL
  } fsm_t;

  // one end entry: partner, flip, a hang, b hang, evalue, score
  typedef struct packed {
    logic [ID_W-1:0]          partner;
    logic                     flip;
    logic signed [HANG_W-1:0] ah;
    logic signed [HANG_W-1:0] bh;
    logic [EV_W-1:0]          ev;
    logic [SC_W-1:0]          score;
  } entry_t;

  // per read: length plus contained, suspicious and member marks
  typedef struct packed {
    logic [RL_W-1:0] len;
    logic            cont;
    logic            susp;
    logic            memb;
  } rinfo_t;

endpackage

// File: hdl/boet_read_mem.sv
module boet_read_mem #(
  parameter int DEPTH = boet_pkg::READ_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic [AW-1:0]        ra0,
  input  logic [AW-1:0]        ra1,
  output boet_pkg::rinfo_t     rd0,
  output boet_pkg::rinfo_t     rd1,
  input  logic                 we,
  input  logic [AW-1:0]        wa,
  input  boet_pkg::rinfo_t     wd
);
  boet_pkg::rinfo_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end
endmodule

// File: hdl/boet_end_mem.sv
module boet_end_mem #(
  parameter int DEPTH = 2 * boet_pkg::READ_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic [AW-1:0]     ra,
  output boet_pkg::entry_t  rd,
  input  logic              we,
  input  logic [AW-1:0]     wa,
  input  boet_pkg::entry_t  wd
);
  boet_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end
endmodule

// File: hdl/best_overlap_edge_table_core.sv
// channel  signals                                          dir
// in       in_valid in_ready opcode read_a read_b a_hang     in
//          b_hang evalue error_rate flipped end_select read_length
// out      out_valid out_ready status best_* is_contained    out
// cfg      cfg_valid cfg_ready cfg_index cfg_data            in
// Each item passes through accept, read, and evaluate and write back; the
// clear opcodes, which visit both ends, repeat the read and evaluate steps,
// and the result is registered at the end of the last evaluate step.
// After reset a clearing pass writes every read and end entry, one end
// entry per cycle, with no item accepted meanwhile.
// The result register holds while out_ready is low; the next item is
// accepted but holds in its read step until the result is taken.
module best_overlap_edge_table_core #(
  parameter int READ_COUNT  = boet_pkg::READ_COUNT_DEF,
  parameter int LENGTH_BITS = boet_pkg::LENGTH_BITS_DEF,
  parameter int EVALUE_BITS = boet_pkg::EVALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [15:0] read_a,
  input  logic [15:0] read_b,
  input  logic signed [20:0] a_hang,
  input  logic signed [20:0] b_hang,
  input  logic [11:0] evalue,
  input  logic [15:0] error_rate,
  input  logic        flipped,
  input  logic        end_select,
  input  logic [19:0] read_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [15:0] best_partner,
  output logic        best_flipped,
  output logic [31:0] best_score,
  output logic signed [20:0] best_a_hang,
  output logic signed [20:0] best_b_hang,
  output logic [11:0] best_evalue,
  output logic        is_contained,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int RAW = $clog2(READ_COUNT);
  localparam int EAW = RAW + 1;
  localparam int LW  = 32 - EVALUE_BITS;
  localparam logic [31:0] MAXEV = 32'((64'd1 << EVALUE_BITS) - 1);
  localparam logic [33:0] LENMAX = 34'((64'd1 << LW) - 1);
  localparam logic [19:0] LMAX20 = 20'((64'd1 << LENGTH_BITS) - 1);

  boet_pkg::fsm_t state, state_next;

  logic [15:0] good_lim, fb_lim;
  logic        restr;

  // latched item
  logic [2:0]  op;
  logic [15:0] ia, ib;
  logic signed [20:0] iah, ibh;
  logic [11:0] iev;
  logic [15:0] ier;
  logic        ifl, ies;
  logic [19:0] irl;
  logic        pass2;   // second end of a clear opcode

  logic [EAW-1:0] clr_cnt;

  boet_pkg::rinfo_t ra_d, rb_d, rwd;
  logic [RAW-1:0] rra0, rra1, rwa;
  logic rwe;
  boet_pkg::entry_t e_d, ewd;
  logic [EAW-1:0] era, ewa;
  logic ewe;

  boet_read_mem #(.DEPTH(READ_COUNT), .AW(RAW)) u_rmem (
    .clk(clk), .ra0(rra0), .ra1(rra1), .rd0(ra_d), .rd1(rb_d),
    .we(rwe), .wa(rwa), .wd(rwd));

  boet_end_mem #(.DEPTH(2*READ_COUNT), .AW(EAW)) u_emem (
    .clk(clk), .ra(era), .rd(e_d), .we(ewe), .wa(ewa), .wd(ewd));

  function automatic logic vid(input logic [15:0] id);
    return id != 16'd0 && 32'(id) < READ_COUNT;
  endfunction

  logic va, vb;
  assign va = vid(ia);
  assign vb = vid(ib);

  boet_pkg::rinfo_t ainf, binf;
  always_comb begin
    ainf = va ? ra_d : '0;
    binf = vb ? rb_d : '0;
  end

  logic end_bit;
  always_comb begin
    if (op == boet_pkg::OP_SCORE_EDGE) end_bit = iah > 0;
    else if (op == boet_pkg::OP_CLEAR_IF_CONT || op == boet_pkg::OP_CLEAR_READ)
      end_bit = pass2 ? ies : ~ies;
    else end_bit = ies;
  end

  // evaluation
  logic bad, rst_fail, shape_c, shape_e;
  logic signed [22:0] leng;
  logic [33:0] lclamp;
  logic [31:0] score;
  logic [11:0] evc;
  always_comb begin
    bad = ainf.len == '0 || binf.len == '0 ||
          !(ier <= good_lim || (good_lim == 16'd0 && ier <= fb_lim));
    rst_fail = restr && !(ainf.memb && binf.memb);
    shape_c = (iah == 0 && ibh == 0 && ia > ib) || iah > 0 || ibh < 0;
    shape_e = (iah >= 0 && ibh <= 0) || (iah <= 0 && ibh >= 0);
    if (iah > 0) leng = $signed({3'b0, ainf.len}) - 23'(iah);
    else         leng = $signed({3'b0, ainf.len}) + 23'(ibh);
    if (leng < 0) lclamp = '0;
    else if (34'(leng) > LENMAX) lclamp = LENMAX;
    else lclamp = 34'(leng);
    evc = (32'(iev) > MAXEV) ? 12'(MAXEV) : iev;
    score = (32'(lclamp) << EVALUE_BITS) | (MAXEV - 32'(evc));
  end

  boet_pkg::status_t st_c;
  logic ewe_eval, rwe_eval;
  boet_pkg::entry_t ew_eval;
  boet_pkg::rinfo_t rw_eval;
  always_comb begin
    st_c = boet_pkg::ST_DONE;
    ewe_eval = 1'b0;
    rwe_eval = 1'b0;
    ew_eval = e_d;
    rw_eval = ra_d;
    case (op)
      boet_pkg::OP_SET_LENGTH: begin
        rwe_eval = va;
        rw_eval.len = (irl > LMAX20) ? LMAX20 : irl;
      end
      boet_pkg::OP_MARK_SUSP: begin
        rwe_eval = va; rw_eval.susp = 1'b1;
      end
      boet_pkg::OP_MARK_MEMBER: begin
        rwe_eval = va; rw_eval.memb = 1'b1;
      end
      boet_pkg::OP_SCORE_CONTAIN: begin
        if (bad) st_c = boet_pkg::ST_BAD_QUALITY;
        else if (rst_fail) st_c = boet_pkg::ST_RESTRICTED;
        else if (shape_c) st_c = boet_pkg::ST_SHAPE;
        else begin
          st_c = boet_pkg::ST_MARKED;
          rwe_eval = 1'b1; rw_eval.cont = 1'b1;
        end
      end
      boet_pkg::OP_SCORE_EDGE: begin
        if (bad) st_c = boet_pkg::ST_BAD_QUALITY;
        else if (rst_fail) st_c = boet_pkg::ST_RESTRICTED;
        else if (binf.susp) st_c = boet_pkg::ST_SUSPICIOUS;
        else if (shape_e) st_c = boet_pkg::ST_SHAPE;
        else if (binf.cont) st_c = boet_pkg::ST_CONTAINED;
        else if (score <= e_d.score) st_c = boet_pkg::ST_NOT_BETTER;
        else begin
          st_c = boet_pkg::ST_NEW_BEST;
          ewe_eval = 1'b1;
          ew_eval = '{partner: ib, flip: ifl, ah: iah, bh: ibh, ev: iev,
                      score: score};
        end
      end
      boet_pkg::OP_CLEAR_IF_CONT: begin
        ewe_eval = va && ra_d.cont;
        ew_eval = '0;
      end
      boet_pkg::OP_READ_BEST: ;
      default: begin
        ewe_eval = va;
        ew_eval = '0;
        rwe_eval = va && !pass2;
        rw_eval.cont = 1'b0; rw_eval.susp = 1'b0; rw_eval.memb = 1'b0;
      end
    endcase
  end

  logic two_pass;
  assign two_pass = op == boet_pkg::OP_CLEAR_IF_CONT || op == boet_pkg::OP_CLEAR_READ;

  always_comb begin
    state_next = state;
    case (state)
      boet_pkg::S_CLEAR:
        if (clr_cnt == EAW'(2*READ_COUNT - 1)) state_next = boet_pkg::S_IDLE;
      boet_pkg::S_IDLE: if (in_valid) state_next = boet_pkg::S_READ;
      // hold until the result register is free or being taken
      boet_pkg::S_READ: if (!out_valid || out_ready) state_next = boet_pkg::S_EVAL;
      boet_pkg::S_EVAL:
        state_next = (two_pass && !pass2) ? boet_pkg::S_READ : boet_pkg::S_IDLE;
      default: state_next = boet_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = state == boet_pkg::S_IDLE;
    cfg_ready = 1'b1;
    rra0 = RAW'(ia);
    rra1 = RAW'(ib);
    era  = {RAW'(ia), end_bit};
    rwe = 1'b0; rwa = RAW'(ia); rwd = rw_eval;
    ewe = 1'b0; ewa = {RAW'(ia), end_bit}; ewd = ew_eval;
    case (state)
      boet_pkg::S_CLEAR: begin
        ewe = 1'b1; ewa = clr_cnt; ewd = '0;
        rwe = clr_cnt[0] == 1'b0; rwa = clr_cnt[EAW-1:1]; rwd = '0;
      end
      boet_pkg::S_EVAL: begin
        ewe = ewe_eval;
        rwe = rwe_eval;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= boet_pkg::S_CLEAR;
      clr_cnt <= '0;
      good_lim <= 16'd655;
      fb_lim <= 16'd655;
      restr <= 1'b0;
      out_valid <= 1'b0;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      if (state == boet_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_valid) begin
        case (cfg_index)
          boet_pkg::CFG_GOOD:     good_lim <= cfg_data;
          boet_pkg::CFG_FALLBACK: fb_lim <= cfg_data;
          boet_pkg::CFG_RESTRICT: restr <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == boet_pkg::S_IDLE && in_valid) pass2 <= 1'b0;
      if (state == boet_pkg::S_EVAL && two_pass && !pass2) pass2 <= 1'b1;
      if (state == boet_pkg::S_EVAL && !(two_pass && !pass2)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == boet_pkg::S_IDLE && in_valid) begin
      op <= opcode; ia <= read_a; ib <= read_b; iah <= a_hang; ibh <= b_hang;
      iev <= evalue; ier <= error_rate; ifl <= flipped; ies <= end_select;
      irl <= read_length;
    end
    // final pass addresses the reported end; build result from written data
    if (state == boet_pkg::S_EVAL && !(two_pass && !pass2)) begin
      status <= st_c;
      if (va) begin
        best_partner <= ewe_eval ? ew_eval.partner : e_d.partner;
        best_flipped <= ewe_eval ? ew_eval.flip : e_d.flip;
        best_score   <= ewe_eval ? ew_eval.score : e_d.score;
        best_a_hang  <= ewe_eval ? ew_eval.ah : e_d.ah;
        best_b_hang  <= ewe_eval ? ew_eval.bh : e_d.bh;
        best_evalue  <= ewe_eval ? ew_eval.ev : e_d.ev;
        is_contained <= rwe_eval ? rw_eval.cont : ra_d.cont;
      end else begin
        best_partner <= '0; best_flipped <= 1'b0; best_score <= '0;
        best_a_hang <= '0; best_b_hang <= '0; best_evalue <= '0;
        is_contained <= 1'b0;
      end
    end
  end
endmodule

// File: tb/best_overlap_edge_table_checker.sv
module best_overlap_edge_table_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [15:0] read_a,
  input  logic [15:0] read_b,
  input  logic signed [20:0] a_hang,
  input  logic signed [20:0] b_hang,
  input  logic [11:0] evalue,
  input  logic [15:0] error_rate,
  input  logic        flipped,
  input  logic        end_select,
  input  logic [19:0] read_length,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  status,
  input  logic [15:0] best_partner,
  input  logic        best_flipped,
  input  logic [31:0] best_score,
  input  logic signed [20:0] best_a_hang,
  input  logic signed [20:0] best_b_hang,
  input  logic [11:0] best_evalue,
  input  logic        is_contained,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          error_count,
  output int          pending,
  output int          result_count
);

  localparam logic [11:0] MAX_EV = 12'hFFF;
  localparam int LEN_SAT = (1 << 20) - 1;

  typedef struct packed {
    logic [15:0] partner;
    logic        flip;
    logic signed [20:0] ah;
    logic signed [20:0] bh;
    logic [11:0] ev;
  } edge_rec_t;

  typedef struct packed {
    logic [3:0]  st;
    logic [15:0] partner;
    logic        flip;
    logic [31:0] score;
    logic signed [20:0] ah;
    logic signed [20:0] bh;
    logic [11:0] ev;
    logic        cont;
  } best_view_t;

  bit [19:0] len_tab  [65536];
  bit        cont_mark[65536];
  bit        susp_mark[65536];
  bit        memb_mark[65536];
  bit [31:0] end_score[131072];
  edge_rec_t end_edge [131072];

  logic [15:0] good_lim = 16'd655;
  logic [15:0] fall_lim = 16'd655;
  logic        restrict_on = 1'b0;

  best_view_t expected_views[$];

  initial begin
    error_count  = 0;
    pending      = 0;
    result_count = 0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (error_count < 30)
      $display("MISMATCH result %0d %s: got %0h want %0h", result_count, what, got, want);
    error_count++;
  endtask

  function automatic bit poor_quality(logic [15:0] a, logic [15:0] b, logic [15:0] er);
    if (len_tab[a] == 0 || len_tab[b] == 0) return 1'b1;
    if (er <= good_lim) return 1'b0;
    if (good_lim == 0 && er <= fall_lim) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit blocked_by_restrict(logic [15:0] a, logic [15:0] b);
    return restrict_on && !(memb_mark[a] && memb_mark[b]);
  endfunction

  function automatic void wipe_ends(logic [15:0] a);
    if (a == 0) return;
    end_edge[{a, 1'b0}]  = '0;
    end_edge[{a, 1'b1}]  = '0;
    end_score[{a, 1'b0}] = '0;
    end_score[{a, 1'b1}] = '0;
  endfunction

  function automatic logic [3:0] rank_edge(logic [15:0] a, logic [15:0] b,
      logic signed [20:0] ah, logic signed [20:0] bh, logic [11:0] ev,
      logic [15:0] er, logic fl);
    int leng;
    logic [31:0] sc;
    logic [16:0] slot;
    if (poor_quality(a, b, er)) return boet_pkg::ST_BAD_QUALITY;
    if (blocked_by_restrict(a, b)) return boet_pkg::ST_RESTRICTED;
    if (susp_mark[b]) return boet_pkg::ST_SUSPICIOUS;
    if ((ah >= 0 && bh <= 0) || (ah <= 0 && bh >= 0)) return boet_pkg::ST_SHAPE;
    if (cont_mark[b]) return boet_pkg::ST_CONTAINED;
    leng = (ah > 0) ? int'(len_tab[a]) - int'(ah) : int'(len_tab[a]) + int'(bh);
    if (leng < 0) leng = 0;
    if (leng > LEN_SAT) leng = LEN_SAT;
    sc = (32'(leng) << 12) | 32'(MAX_EV - ev);
    slot = {a, ah > 0};
    if (sc <= end_score[slot]) return boet_pkg::ST_NOT_BETTER;
    end_score[slot] = sc;
    end_edge[slot]  = '{partner: b, flip: fl, ah: ah, bh: bh, ev: ev};
    return boet_pkg::ST_NEW_BEST;
  endfunction

  function automatic best_view_t apply_item(logic [2:0] op, logic [15:0] a, logic [15:0] b,
      logic signed [20:0] ah, logic signed [20:0] bh, logic [11:0] ev, logic [15:0] er,
      logic fl, logic es, logic [19:0] rl);
    best_view_t v;
    logic sel;
    logic [16:0] slot;
    v = '0;
    v.st = boet_pkg::ST_DONE;
    sel = es;
    case (boet_pkg::opcode_t'(op))
      boet_pkg::OP_SET_LENGTH:    if (a != 0) len_tab[a] = rl;
      boet_pkg::OP_MARK_SUSP:     if (a != 0) susp_mark[a] = 1'b1;
      boet_pkg::OP_MARK_MEMBER:   if (a != 0) memb_mark[a] = 1'b1;
      boet_pkg::OP_SCORE_CONTAIN: begin
        if (poor_quality(a, b, er)) v.st = boet_pkg::ST_BAD_QUALITY;
        else if (blocked_by_restrict(a, b)) v.st = boet_pkg::ST_RESTRICTED;
        else if ((ah == 0 && bh == 0 && a > b) || ah > 0 || bh < 0)
          v.st = boet_pkg::ST_SHAPE;
        else begin
          cont_mark[a] = 1'b1;
          v.st = boet_pkg::ST_MARKED;
        end
      end
      boet_pkg::OP_SCORE_EDGE: begin
        sel = ah > 0;
        v.st = rank_edge(a, b, ah, bh, ev, er, fl);
      end
      boet_pkg::OP_CLEAR_IF_CONT: if (cont_mark[a]) wipe_ends(a);
      boet_pkg::OP_READ_BEST: ;
      default: begin
        wipe_ends(a);
        if (a != 0) begin
          cont_mark[a] = 1'b0;
          susp_mark[a] = 1'b0;
          memb_mark[a] = 1'b0;
        end
      end
    endcase
    if (a != 0) begin
      slot = {a, sel};
      v.partner = end_edge[slot].partner;
      v.flip    = end_edge[slot].flip;
      v.score   = end_score[slot];
      v.ah      = end_edge[slot].ah;
      v.bh      = end_edge[slot].bh;
      v.ev      = end_edge[slot].ev;
      v.cont    = cont_mark[a];
    end
    return v;
  endfunction

  always @(posedge clk) begin
    best_view_t w;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_views.push_back(apply_item(opcode, read_a, read_b, a_hang, b_hang, evalue,
                                            error_rate, flipped, end_select, read_length));
      if (out_valid && out_ready) begin
        if (expected_views.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          w = expected_views.pop_front();
          if (status != w.st) report("status", status, w.st);
          if (best_partner != w.partner) report("partner", best_partner, w.partner);
          if (best_flipped != w.flip) report("flipped", best_flipped, w.flip);
          if (best_score != w.score) report("score", best_score, w.score);
          if (best_a_hang != w.ah) report("a_hang", best_a_hang, w.ah);
          if (best_b_hang != w.bh) report("b_hang", best_b_hang, w.bh);
          if (best_evalue != w.ev) report("evalue", best_evalue, w.ev);
          if (is_contained != w.cont) report("contained", is_contained, w.cont);
        end
        result_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          boet_pkg::CFG_GOOD:     good_lim = cfg_data;
          boet_pkg::CFG_FALLBACK: fall_lim = cfg_data;
          boet_pkg::CFG_RESTRICT: restrict_on = cfg_data[0];
          default: ;
        endcase
      end
      pending = expected_views.size();
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;

  localparam int IDLE_LIMIT = 600000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [2:0] opcode;
  logic [15:0] read_a, read_b;
  logic signed [20:0] a_hang, b_hang;
  logic [11:0] evalue;
  logic [15:0] error_rate;
  logic flipped, end_select;
  logic [19:0] read_length;
  logic out_valid, out_ready;
  logic [3:0] status;
  logic [15:0] best_partner;
  logic best_flipped;
  logic [31:0] best_score;
  logic signed [20:0] best_a_hang, best_b_hang;
  logic [11:0] best_evalue;
  logic is_contained;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  int error_count, pending, result_count;
  int idle_pct = 0, stall_pct = 0;
  int sent_count = 0;
  int idle_cycles = 0;

  best_overlap_edge_table_core dut (.*);

  best_overlap_edge_table_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off early on
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 60) begin
        held = 1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0 || in_valid) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic send_beat(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
      input logic signed [20:0] ah, input logic signed [20:0] bh, input logic [11:0] ev,
      input logic [15:0] er, input logic fl, input logic es, input logic [19:0] rl);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    opcode <= op; read_a <= a; read_b <= b; a_hang <= ah; b_hang <= bh;
    evalue <= ev; error_rate <= er; flipped <= fl; end_select <= es; read_length <= rl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_read();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 16'd0;
    if (r < 9) return 16'($urandom);
    return 16'($urandom_range(1, 12));
  endfunction

  task automatic send_random();
    int r, k;
    logic [2:0] op;
    logic signed [20:0] ah, bh;
    logic [19:0] rl;
    logic [15:0] er;
    r = $urandom_range(99);
    if (r < 12) op = boet_pkg::OP_SET_LENGTH;
    else if (r < 16) op = boet_pkg::OP_MARK_SUSP;
    else if (r < 24) op = boet_pkg::OP_MARK_MEMBER;
    else if (r < 32) op = boet_pkg::OP_SCORE_CONTAIN;
    else if (r < 80) op = boet_pkg::OP_SCORE_EDGE;
    else if (r < 85) op = boet_pkg::OP_CLEAR_IF_CONT;
    else if (r < 96) op = boet_pkg::OP_READ_BEST;
    else op = boet_pkg::OP_CLEAR_READ;
    k = $urandom_range(99);
    if (op == boet_pkg::OP_SCORE_CONTAIN && k < 75) begin
      ah = -21'($urandom_range(0, 200));
      bh = 21'($urandom_range(0, 200));
    end else if (k < 70) begin
      ah = 21'($urandom_range(1, 1500));
      bh = 21'($urandom_range(1, 1500));
      if ($urandom_range(1)) begin
        ah = -ah;
        bh = -bh;
      end
    end else if (k < 85) begin
      ah = $urandom_range(1) ? 21'($urandom_range(0, 300)) : -21'($urandom_range(0, 300));
      bh = (ah > 0) ? -21'($urandom_range(0, 300)) : 21'($urandom_range(0, 300));
    end else begin
      ah = 21'($urandom);
      bh = 21'($urandom);
    end
    rl = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(100, 5000));
    er = $urandom_range(1) ? 16'($urandom_range(0, 800)) : 16'($urandom);
    send_beat(op, pick_read(), pick_read(), ah, bh, 12'($urandom), er,
              1'($urandom), 1'($urandom), rl);
  endtask

  task automatic send_directed();
    send_beat(boet_pkg::OP_SET_LENGTH, 16'd1, 0, 0, 0, 0, 0, 0, 0, 20'd1000);
    send_beat(boet_pkg::OP_SET_LENGTH, 16'd2, 0, 0, 0, 0, 0, 0, 0, 20'd2000);
    send_beat(boet_pkg::OP_SET_LENGTH, 16'd4, 0, 0, 0, 0, 0, 0, 0, 20'd500);
    send_beat(boet_pkg::OP_SET_LENGTH, 16'd5, 0, 0, 0, 0, 0, 0, 0, 20'd300);
    send_beat(boet_pkg::OP_SET_LENGTH, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 20'hFFFFF);
    send_beat(boet_pkg::OP_SET_LENGTH, 16'd0, 0, 0, 0, 0, 0, 0, 0, 20'd700);
    // 3' end edge, then a worse one, then a better one
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd2, 21'd100, 21'd50, 12'd10, 16'd0,
              1'b1, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd4, 21'd100, 21'd50, 12'd20, 16'd0,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd4, 21'd50, 21'd50, 12'hFFF, 16'd655,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd2, -21'd30, -21'd40, 12'd0, 16'd1,
              1'b1, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd2, 21'd0, 21'd0, 12'd0, 16'd0,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd3, 21'd5, 21'd5, 12'd0, 16'd0,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd2, 21'd5, 21'd5, 12'd0, 16'hFFFF,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_MARK_SUSP, 16'd4, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd2, 16'd4, 21'd5, 21'd5, 12'd0, 16'd0,
              1'b0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_CONTAIN, 16'd5, 16'd2, -21'd10, 21'd10, 0, 16'd0,
              0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_CONTAIN, 16'd2, 16'd1, 21'd0, 21'd0, 0, 16'd0,
              0, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'd1, 16'd5, -21'd5, -21'd5, 12'd0, 16'd0,
              1'b0, 0, 0);
    // extreme hangs on the largest read, down to a zero overlap length
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'hFFFF, 16'd1, -21'sd1048576, 21'sd1048575,
              12'd0, 0, 1, 0, 0);
    send_beat(boet_pkg::OP_SCORE_EDGE, 16'hFFFF, 16'd2, -21'd1, -21'd1048575,
              12'd0, 0, 1, 0, 0);
    send_beat(boet_pkg::OP_READ_BEST, 16'd1, 0, 0, 0, 0, 0, 0, 1'b1, 0);
    send_beat(boet_pkg::OP_READ_BEST, 16'd1, 0, 0, 0, 0, 0, 0, 1'b0, 0);
    send_beat(boet_pkg::OP_CLEAR_IF_CONT, 16'd5, 0, 0, 0, 0, 0, 0, 0, 0);
    send_beat(boet_pkg::OP_CLEAR_READ, 16'd1, 0, 0, 0, 0, 0, 0, 1'b1, 0);
    send_beat(boet_pkg::OP_READ_BEST, 16'd0, 0, 0, 0, 0, 0, 0, 1'b1, 0);
  endtask

  initial begin
    in_valid = 1'b0; opcode = '0; read_a = '0; read_b = '0; a_hang = '0; b_hang = '0;
    evalue = '0; error_rate = '0; flipped = 1'b0; end_select = 1'b0; read_length = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(boet_pkg::CFG_GOOD, 16'd655);
          write_reg(boet_pkg::CFG_FALLBACK, 16'd655);
          write_reg(boet_pkg::CFG_RESTRICT, 16'd0);
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          write_reg(boet_pkg::CFG_GOOD, 16'd0);
          write_reg(boet_pkg::CFG_FALLBACK, 16'hFFFF);
          idle_pct = 88; stall_pct = 0;
        end
        2: begin
          write_reg(boet_pkg::CFG_GOOD, 16'hFFFF);
          write_reg(boet_pkg::CFG_FALLBACK, 16'd0);
          write_reg(boet_pkg::CFG_RESTRICT, 16'd1);
          idle_pct = 0; stall_pct = 88;
        end
        3: begin
          write_reg(boet_pkg::CFG_GOOD, 16'd0);
          write_reg(boet_pkg::CFG_FALLBACK, 16'd0);
          idle_pct = 12; stall_pct = 12;
        end
        default: begin
          write_reg(boet_pkg::CFG_GOOD, 16'($urandom_range(0, 1200)));
          write_reg(boet_pkg::CFG_FALLBACK, 16'($urandom));
          write_reg(boet_pkg::CFG_RESTRICT, 16'($urandom));
          write_reg(CFG_SPARE, 16'($urandom));
          idle_pct = 0; stall_pct = 0;
        end
      endcase
      if (ph == 0) send_directed();
      for (int i = 0; i < 266; i++) send_random();
      in_valid <= 1'b0;
      drain();
    end

    $display("Sent %0d items over five register settings and four idling patterns,", sent_count);
    $display("checked %0d results including a long output hold-off.", result_count);
    if (error_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: files.f
hdl/boet_pkg.sv
hdl/boet_read_mem.sv
hdl/boet_end_mem.sv
hdl/best_overlap_edge_table_core.sv
tb/best_overlap_edge_table_checker.sv
tb/testbench.sv
